FILE: sv/ebs_pkg.sv
package ebs_pkg;

    // Default sizes
    localparam int MAX_ROWS_DEF = 1024;
    localparam int MAX_DIMS_DEF = 16;

    // Field widths fixed by the interface
    localparam int ROW_PORT_W  = 11;
    localparam int COL_PORT_W  = 4;
    localparam int VALUE_W     = 32;
    localparam int FEATURE_W   = 13;
    localparam int DIMS_REG_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Register reset values
    localparam logic [ROW_PORT_W-1:0] ROWS_RESET = ROW_PORT_W'(1024);
    localparam logic [DIMS_REG_W-1:0] DIMS_RESET = DIMS_REG_W'(16);

    // Register index, taken from paddr[2]
    localparam logic REG_ROWS_IN_USE = 1'b0;
    localparam logic REG_DIMS_IN_USE = 1'b1;

    // Special feature ids
    localparam logic signed [FEATURE_W-1:0] FEATURE_OOV   = -13'sd1;
    localparam logic signed [FEATURE_W-1:0] FEATURE_EMPTY = -13'sd2;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Command kinds passed from front to back
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NOP   = 2'd0;
    localparam kind_t KIND_WRITE = 2'd1;
    localparam kind_t KIND_ADD   = 2'd2;

    // Saturating Q8.24 add
    function automatic logic signed [VALUE_W-1:0] sat_add(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b
    );
        logic signed [VALUE_W:0] s;
        logic signed [VALUE_W-1:0] r;
        s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
        if (s[VALUE_W] != s[VALUE_W-1])
        begin
            r = s[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else
        begin
            r = s[VALUE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/ebs_ram.sv
module ebs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/ebs_queue.sv
module ebs_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int DEPTH = ebs_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: sv/ebs_front.sv
module ebs_front #(
    parameter int MAX_ROWS = ebs_pkg::MAX_ROWS_DEF,
    parameter int MAX_DIMS = ebs_pkg::MAX_DIMS_DEF,
    localparam int ROW_W = $clog2(MAX_ROWS + 1),
    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    localparam int CMD_W = 2 + ROW_W + DIM_W + ebs_pkg::VALUE_W + 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // item side
    input  logic                                push,
    output logic                                full,
    input  logic                                opcode,
    input  logic [ebs_pkg::ROW_PORT_W-1:0]      table_row,
    input  logic [ebs_pkg::COL_PORT_W-1:0]      table_column,
    input  logic signed [ebs_pkg::VALUE_W-1:0]  table_value,
    input  logic signed [ebs_pkg::FEATURE_W-1:0] feature_id,
    input  logic                                bag_end,
    // clamped vocabulary size
    input  logic [ROW_W-1:0]                    rows,
    // command queue side
    output logic                                q_push,
    input  logic                                q_full,
    output logic [CMD_W-1:0]                    q_data
);

    typedef struct packed {
        ebs_pkg::kind_t                    kind;
        logic [ROW_W-1:0]                  row;
        logic [DIM_W-1:0]                  col;
        logic [ebs_pkg::VALUE_W-1:0]       value;
        logic                              err;
        logic                              bag_end;
    } cmd_t;

    cmd_t cmd_next, cmd_reg;
    logic stage_valid_reg, stage_valid_next;
    logic accept;

    assign full   = stage_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = stage_valid_reg && !q_full;
    assign q_data = cmd_reg;

    // Classify the incoming item
    always_comb
    begin
        cmd_next         = '0;
        cmd_next.value   = table_value;
        cmd_next.col     = DIM_W'(table_column);
        if (!opcode)
        begin
            // table write, dropped when outside the table
            if ((int'(table_row) <= MAX_ROWS) && (int'(table_column) < MAX_DIMS))
            begin
                cmd_next.kind = ebs_pkg::KIND_WRITE;
                cmd_next.row  = ROW_W'(table_row);
            end
            else
            begin
                cmd_next.kind = ebs_pkg::KIND_NOP;
            end
        end
        else
        begin
            cmd_next.bag_end = bag_end;
            if (feature_id == ebs_pkg::FEATURE_OOV)
            begin
                cmd_next.kind = ebs_pkg::KIND_ADD;
                cmd_next.row  = rows;
            end
            else if (feature_id == ebs_pkg::FEATURE_EMPTY)
            begin
                cmd_next.kind = ebs_pkg::KIND_NOP;
            end
            else if (feature_id[ebs_pkg::FEATURE_W-1] ||
                     (int'(unsigned'(feature_id)) >= int'(rows)))
            begin
                cmd_next.kind = ebs_pkg::KIND_NOP;
                cmd_next.err  = 1'b1;
            end
            else
            begin
                cmd_next.kind = ebs_pkg::KIND_ADD;
                cmd_next.row  = ROW_W'(unsigned'(feature_id));
            end
        end
    end

    // Stage valid
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

FILE: sv/ebs_back.sv
module ebs_back #(
    parameter int MAX_ROWS = ebs_pkg::MAX_ROWS_DEF,
    parameter int MAX_DIMS = ebs_pkg::MAX_DIMS_DEF,
    localparam int ROW_W = $clog2(MAX_ROWS + 1),
    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    localparam int CNT_W = $clog2(MAX_DIMS + 1),
    localparam int CMD_W = 2 + ROW_W + DIM_W + ebs_pkg::VALUE_W + 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command queue side
    input  logic                               q_empty,
    input  logic [CMD_W-1:0]                   q_data,
    output logic                               q_pop,
    // clamped dimension count
    input  logic [CNT_W-1:0]                   dims,
    // result side
    output logic                               empty,
    input  logic                               pop,
    output logic [ebs_pkg::COL_PORT_W-1:0]     dimension,
    output logic signed [ebs_pkg::VALUE_W-1:0] sum_value,
    output logic                               range_error,
    output logic                               last_of_bag
);

    localparam int VW    = ebs_pkg::VALUE_W;
    localparam int AW    = ROW_W + DIM_W;
    localparam int DEPTH = (MAX_ROWS + 1) * (2 ** DIM_W);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    typedef struct packed {
        ebs_pkg::kind_t    kind;
        logic [ROW_W-1:0]  row;
        logic [DIM_W-1:0]  col;
        logic [VW-1:0]     value;
        logic              err;
        logic              bag_end;
    } cmd_t;

    cmd_t head;

    logic [1:0]             state_reg, state_next;
    logic [DIM_W-1:0]       cnt_reg, cnt_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic                   bag_end_reg, bag_end_next;
    logic                   bag_err_reg, bag_err_next;
    logic                   pipe_valid_reg, pipe_valid_next;
    logic [DIM_W-1:0]       pipe_idx_reg, pipe_idx_next;
    logic signed [VW-1:0]   acc_reg [MAX_DIMS];
    logic                   acc_clear;
    logic                   out_valid_reg, out_valid_next;
    logic [DIM_W-1:0]       out_dim_reg;
    logic signed [VW-1:0]   out_sum_reg;
    logic                   out_err_reg, out_last_reg;
    logic                   out_load, emit_last;
    logic [DIM_W-1:0]       last_idx, acc_idx;
    logic signed [VW-1:0]   acc_rd;

    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [VW-1:0]          ram_rdata;

    assign head      = cmd_t'(q_data);
    assign last_idx  = DIM_W'(dims - CNT_W'(1));
    assign emit_last = (cnt_reg == last_idx);
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || pop);
    assign acc_idx   = (state_reg == S_EMIT) ? cnt_reg : pipe_idx_reg;
    assign acc_rd    = acc_reg[acc_idx];

    // Table memory: writes from idle, row reads during add
    assign ram_we   = (state_reg == S_IDLE) && !q_empty && (head.kind == ebs_pkg::KIND_WRITE);
    assign ram_addr = ram_we ? {head.row, head.col} : {row_reg, cnt_reg};

    ebs_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (head.value),
        .rdata (ram_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        row_next        = row_reg;
        bag_end_next    = bag_end_reg;
        bag_err_next    = bag_err_reg;
        pipe_valid_next = 1'b0;
        pipe_idx_next   = cnt_reg;
        q_pop           = 1'b0;
        acc_clear       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (head.kind)
                        ebs_pkg::KIND_WRITE:
                        begin
                            // memory written above
                        end
                        ebs_pkg::KIND_ADD:
                        begin
                            row_next     = head.row;
                            bag_end_next = head.bag_end;
                            cnt_next     = '0;
                            state_next   = S_ADD;
                        end
                        default:
                        begin
                            if (head.err)
                            begin
                                bag_err_next = 1'b1;
                            end
                            if (head.bag_end)
                            begin
                                cnt_next   = '0;
                                state_next = S_EMIT;
                            end
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                pipe_valid_next = 1'b1;
                if (emit_last)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    cnt_next = cnt_reg + DIM_W'(1);
                end
            end
            S_WAIT:
            begin
                cnt_next   = '0;
                state_next = bag_end_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    if (emit_last)
                    begin
                        acc_clear    = 1'b1;
                        bag_err_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + DIM_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            bag_end_reg    <= 1'b0;
            bag_err_reg    <= 1'b0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            bag_end_reg    <= bag_end_next;
            bag_err_reg    <= bag_err_next;
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Accumulators: one saturating add per cycle, cleared after a bag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (acc_clear)
        begin
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (pipe_valid_reg)
        begin
            acc_reg[pipe_idx_reg] <= ebs_pkg::sat_add(acc_rd, ram_rdata);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        pipe_idx_reg <= pipe_idx_next;
        if (out_load)
        begin
            out_dim_reg  <= cnt_reg;
            out_sum_reg  <= acc_rd;
            out_err_reg  <= bag_err_reg;
            out_last_reg <= emit_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign dimension   = ebs_pkg::COL_PORT_W'(out_dim_reg);
    assign sum_value   = out_sum_reg;
    assign range_error = out_err_reg;
    assign last_of_bag = out_last_reg;

`ifndef ASSERT_OFF
    // table is never written while a row is being read
    a_no_write_in_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD || state_reg == S_WAIT) |-> !ram_we)
        else $error("table write during row read");

    // commands leave the queue only when the sequencer is idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE))
        else $error("queue popped outside idle");

    // last dimension of a bag returns to idle with flag and first sum cleared
    a_bag_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && emit_last) |=> (state_reg == S_IDLE && !bag_err_reg &&
                                     acc_reg[0] == '0))
        else $error("bag state not cleared after emission");

    // an add in flight always comes from a read issued in the add state
    a_pipe_source: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg |-> ($past(state_reg) == S_ADD))
        else $error("accumulate without row read");
`endif

endmodule

FILE: sv/embedding_bag_sum_top.sv
// Channel  | Handshake              | Fields
// ---------+------------------------+-----------------------------------------------
// items in | push / full            | opcode, table_row, table_column, table_value,
//          |                        | feature_id, bag_end
// sums out | pop / empty            | dimension, sum_value, range_error, last_of_bag
// config   | APB psel/penable/pready| rows_in_use @0x0, dims_in_use @0x4
//
// Table writes and skipped or out-of-range features are taken in the back-end idle state.
// A feature that adds a row is popped in idle, then reads the table memory once per
// dimension through the single RAM port in the add state and drains in a wait state.
// A bag end emits dims items, one per cycle while pop keeps up.
// Reset clears control, accumulators and configuration registers; the table is not cleared.
// A four-entry command queue lets the front keep taking items while the back
// is busy or the output is stalled.
module embedding_bag_sum_top #(
    parameter int MAX_ROWS = ebs_pkg::MAX_ROWS_DEF,
    parameter int MAX_DIMS = ebs_pkg::MAX_DIMS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // items
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 opcode,
    input  logic [ebs_pkg::ROW_PORT_W-1:0]       table_row,
    input  logic [ebs_pkg::COL_PORT_W-1:0]       table_column,
    input  logic signed [ebs_pkg::VALUE_W-1:0]   table_value,
    input  logic signed [ebs_pkg::FEATURE_W-1:0] feature_id,
    input  logic                                 bag_end,
    // results
    output logic                                 empty,
    input  logic                                 pop,
    output logic [ebs_pkg::COL_PORT_W-1:0]       dimension,
    output logic signed [ebs_pkg::VALUE_W-1:0]   sum_value,
    output logic                                 range_error,
    output logic                                 last_of_bag,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ebs_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [ebs_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [ebs_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W = $clog2(MAX_DIMS + 1);
    localparam int CMD_W = 2 + ROW_W + DIM_W + ebs_pkg::VALUE_W + 2;

    logic [ebs_pkg::ROW_PORT_W-1:0] rows_in_use_reg;
    logic [ebs_pkg::DIMS_REG_W-1:0] dims_in_use_reg;
    logic [ROW_W-1:0]               rows;
    logic [CNT_W-1:0]               dims;
    logic                           cfg_write;

    logic                           q_push, q_full, q_pop, q_empty;
    logic [CMD_W-1:0]               q_wdata, q_rdata;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= ebs_pkg::ROWS_RESET;
            dims_in_use_reg <= ebs_pkg::DIMS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                ebs_pkg::REG_ROWS_IN_USE:
                begin
                    rows_in_use_reg <= pwdata[ebs_pkg::ROW_PORT_W-1:0];
                end
                ebs_pkg::REG_DIMS_IN_USE:
                begin
                    dims_in_use_reg <= pwdata[ebs_pkg::DIMS_REG_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ebs_pkg::REG_ROWS_IN_USE: prdata = ebs_pkg::APB_DATA_W'(rows_in_use_reg);
            ebs_pkg::REG_DIMS_IN_USE: prdata = ebs_pkg::APB_DATA_W'(dims_in_use_reg);
            default:                  prdata = '0;
        endcase
    end

    // Clamp the registers to the sizes the table supports
    always_comb
    begin
        if (rows_in_use_reg == '0)
        begin
            rows = ROW_W'(1);
        end
        else if (int'(rows_in_use_reg) > MAX_ROWS)
        begin
            rows = ROW_W'(MAX_ROWS);
        end
        else
        begin
            rows = ROW_W'(rows_in_use_reg);
        end

        if (dims_in_use_reg == '0)
        begin
            dims = CNT_W'(1);
        end
        else if (int'(dims_in_use_reg) > MAX_DIMS)
        begin
            dims = CNT_W'(MAX_DIMS);
        end
        else
        begin
            dims = CNT_W'(dims_in_use_reg);
        end
    end

    ebs_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_DIMS (MAX_DIMS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .table_row    (table_row),
        .table_column (table_column),
        .table_value  (table_value),
        .feature_id   (feature_id),
        .bag_end      (bag_end),
        .rows         (rows),
        .q_push       (q_push),
        .q_full       (q_full),
        .q_data       (q_wdata)
    );

    ebs_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .wdata (q_wdata),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    ebs_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_DIMS (MAX_DIMS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .dims        (dims),
        .empty       (empty),
        .pop         (pop),
        .dimension   (dimension),
        .sum_value   (sum_value),
        .range_error (range_error),
        .last_of_bag (last_of_bag)
    );

endmodule

FILE: sim/tb_embedding_bag_sum_top.sv
`timescale 1ns / 100ps

module tb_embedding_bag_sum_top;

    // sizes and codes shared with the block
    localparam int VALUE_W    = ebs_pkg::VALUE_W;
    localparam int ROW_PORT_W = ebs_pkg::ROW_PORT_W;
    localparam int COL_PORT_W = ebs_pkg::COL_PORT_W;
    localparam int FEATURE_W  = ebs_pkg::FEATURE_W;
    localparam int DIMS_REG_W = ebs_pkg::DIMS_REG_W;
    localparam int APB_ADDR_W = ebs_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = ebs_pkg::APB_DATA_W;
    localparam logic [ROW_PORT_W-1:0] ROWS_RESET = ebs_pkg::ROWS_RESET;
    localparam logic [DIMS_REG_W-1:0] DIMS_RESET = ebs_pkg::DIMS_RESET;
    localparam logic REG_ROWS_IN_USE = ebs_pkg::REG_ROWS_IN_USE;
    localparam logic REG_DIMS_IN_USE = ebs_pkg::REG_DIMS_IN_USE;
    localparam logic signed [FEATURE_W-1:0] FEATURE_OOV   = ebs_pkg::FEATURE_OOV;
    localparam logic signed [FEATURE_W-1:0] FEATURE_EMPTY = ebs_pkg::FEATURE_EMPTY;

    localparam int MAX_ROWS        = ebs_pkg::MAX_ROWS_DEF;
    localparam int MAX_DIMS        = ebs_pkg::MAX_DIMS_DEF;
    localparam int TABLE_WORDS     = (MAX_ROWS + 1) * MAX_DIMS;
    localparam int RANDOM_ITEMS    = 350;
    localparam int PHASE_ITEMS     = 60;
    localparam int QUIET_ITEMS     = 80;
    localparam int SETTLE_CYCLES   = 200;
    localparam int POP_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int MAX_PRINTED     = 100;

    // item kinds
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    // Q8.24 limits and a few handy values
    localparam logic signed [VALUE_W-1:0] Q_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] Q_MIN    = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] Q_ONE    = 32'sh0100_0000;
    localparam logic signed [VALUE_W-1:0] Q_HALF   = 32'sh0080_0000;
    localparam logic signed [VALUE_W-1:0] Q_EPS_NEG = -32'sd1;

    typedef struct packed {
        logic [COL_PORT_W-1:0]     dim;
        logic signed [VALUE_W-1:0] sum;
        logic                      err;
        logic                      last;
    } bag_sum_t;

    logic                        clk;
    logic                        rst_n;
    logic                        push;
    logic                        full;
    logic                        opcode;
    logic [ROW_PORT_W-1:0]       table_row;
    logic [COL_PORT_W-1:0]       table_column;
    logic signed [VALUE_W-1:0]   table_value;
    logic signed [FEATURE_W-1:0] feature_id;
    logic                        bag_end;
    logic                        empty;
    logic                        pop;
    logic [COL_PORT_W-1:0]       dimension;
    logic signed [VALUE_W-1:0]   sum_value;
    logic                        range_error;
    logic                        last_of_bag;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [APB_ADDR_W-1:0]       paddr;
    logic [APB_DATA_W-1:0]       pwdata;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;

    // predictor state
    logic [VALUE_W-1:0]        table_words [TABLE_WORDS];
    bit                        word_loaded [TABLE_WORDS];
    logic signed [VALUE_W-1:0] dim_sums [MAX_DIMS] = '{default: '0};
    bit                        bag_err = 1'b0;
    logic [ROW_PORT_W-1:0]     rows_reg = ROWS_RESET;
    logic [DIMS_REG_W-1:0]     dims_reg = DIMS_RESET;
    bag_sum_t                  pending_sums [$];

    // run control and bookkeeping
    bit idle_on = 1'b1;
    int pop_hold_req = 0;
    int cycle_count = 0;
    int errors = 0;
    int items_sent = 0;
    int bags_closed = 0;
    int sums_checked = 0;
    int configs_written = 0;
    int full_stall_cycles = 0;

    embedding_bag_sum_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .table_row    (table_row),
        .table_column (table_column),
        .table_value  (table_value),
        .feature_id   (feature_id),
        .bag_end      (bag_end),
        .empty        (empty),
        .pop          (pop),
        .dimension    (dimension),
        .sum_value    (sum_value),
        .range_error  (range_error),
        .last_of_bag  (last_of_bag),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // registers are clamped to their legal range when used
    function automatic int rows_now();
        int r;
        r = int'(rows_reg);
        if (r < 1)
        begin
            return 1;
        end
        if (r > MAX_ROWS)
        begin
            return MAX_ROWS;
        end
        return r;
    endfunction

    function automatic int dims_now();
        int d;
        d = int'(dims_reg);
        if (d < 1)
        begin
            return 1;
        end
        if (d > MAX_DIMS)
        begin
            return MAX_DIMS;
        end
        return d;
    endfunction

    // table update or accumulate for one accepted item; queues sums on bag end
    function automatic void bag_sum_step(input logic op, input logic [ROW_PORT_W-1:0] row,
                                         input logic [COL_PORT_W-1:0] col,
                                         input logic [VALUE_W-1:0] value,
                                         input logic signed [FEATURE_W-1:0] fid,
                                         input logic ends_bag);
        int rows;
        int dims;
        int id;
        int src;
        logic signed [VALUE_W:0] s;
        bag_sum_t r;
        rows = rows_now();
        dims = dims_now();
        id = int'(fid);
        src = -1;
        if (op == OP_WRITE)
        begin
            // rows past MAX_ROWS and columns past the table are dropped
            if (int'(row) <= MAX_ROWS && int'(col) < MAX_DIMS)
            begin
                table_words[row * MAX_DIMS + col] = value;
                word_loaded[row * MAX_DIMS + col] = 1'b1;
            end
            return;
        end
        if (fid == FEATURE_OOV)
        begin
            src = rows;
        end
        else if (fid == FEATURE_EMPTY)
        begin
            src = -1;
        end
        else if (id < 0 || id >= rows)
        begin
            bag_err = 1'b1;
        end
        else
        begin
            src = id;
        end
        // saturating add of the selected row
        if (src >= 0)
        begin
            for (int d = 0; d < dims; d++)
            begin
                s = dim_sums[d] + signed'(table_words[src * MAX_DIMS + d]);
                if (s > Q_MAX)
                begin
                    dim_sums[d] = Q_MAX;
                end
                else if (s < Q_MIN)
                begin
                    dim_sums[d] = Q_MIN;
                end
                else
                begin
                    dim_sums[d] = s[VALUE_W-1:0];
                end
            end
        end
        if (ends_bag)
        begin
            for (int d = 0; d < dims; d++)
            begin
                r.dim  = COL_PORT_W'(d);
                r.sum  = dim_sums[d];
                r.err  = bag_err;
                r.last = (d == dims - 1);
                pending_sums.push_back(r);
            end
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                dim_sums[d] = '0;
            end
            bag_err = 1'b0;
            bags_closed++;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTED)
        begin
            $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
        end
    endtask

    // offer one item, optionally after an idle burst, and predict on acceptance
    task automatic send_item(input logic op, input logic [ROW_PORT_W-1:0] row,
                             input logic [COL_PORT_W-1:0] col,
                             input logic [VALUE_W-1:0] value,
                             input logic signed [FEATURE_W-1:0] fid,
                             input logic ends_bag);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push         <= 1'b1;
        opcode       <= op;
        table_row    <= row;
        table_column <= col;
        table_value  <= value;
        feature_id   <= fid;
        bag_end      <= ends_bag;
        forever
        begin
            @(posedge clk);
            if (full === 1'b0)
            begin
                break;
            end
            full_stall_cycles++;
        end
        bag_sum_step(op, row, col, value, fid, ends_bag);
        if (!(op == OP_WRITE && int'(row) > MAX_ROWS))
        begin
            items_sent++;
        end
    endtask

    task automatic stop_push();
        @(negedge clk);
        push <= 1'b0;
    endtask

    // sender waits for every pending sum, then lets the back end go quiet
    task automatic quiesce();
        stop_push();
        while (pending_sums.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        if (idx == REG_ROWS_IN_USE)
        begin
            rows_reg = data[ROW_PORT_W-1:0];
        end
        else
        begin
            dims_reg = data[DIMS_REG_W-1:0];
        end
        configs_written++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper bits carry junk; only the low field counts
    task automatic set_config(input int rows, input int dims);
        apb_write(REG_ROWS_IN_USE, ($urandom << ROW_PORT_W) | rows);
        apb_write(REG_DIMS_IN_USE, ($urandom << DIMS_REG_W) | dims);
    endtask

    function automatic logic [VALUE_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return Q_MAX;
            1: return Q_MIN;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
        endcase
    endfunction

    // fill in any word of a row that a lookup would read but was never loaded
    task automatic load_row(input int r);
        for (int d = 0; d < dims_now(); d++)
        begin
            if (!word_loaded[r * MAX_DIMS + d])
            begin
                send_item(OP_WRITE, ROW_PORT_W'(r), COL_PORT_W'(d), rand_word(),
                          FEATURE_W'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic send_feature(input int id, input logic ends_bag);
        int rows;
        int src;
        rows = rows_now();
        src = -1;
        if (id == int'(FEATURE_OOV))
        begin
            src = rows;
        end
        else if (id >= 0 && id < rows)
        begin
            src = id;
        end
        if (src >= 0)
        begin
            load_row(src);
        end
        send_item(OP_FEATURE, ROW_PORT_W'($urandom), COL_PORT_W'($urandom), $urandom,
                  FEATURE_W'(id), ends_bag);
    endtask

    function automatic int pick_feature();
        int rows;
        logic signed [FEATURE_W-1:0] raw;
        rows = rows_now();
        raw = FEATURE_W'($urandom);
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5: return (rows <= 8) ? int'($urandom_range(0, rows - 1))
                                                 : int'($urandom_range(0, 7));
            6: return rows - 1;
            7: return int'($urandom_range(0, rows - 1));
            8, 9, 10: return int'(FEATURE_OOV);
            11: return int'(FEATURE_EMPTY);
            12, 13: return int'($urandom_range(rows, 4095));
            14: return -3 - int'($urandom_range(0, 4093));
            default: return int'(raw);
        endcase
    endfunction

    // saturation both ways, OOV, empty slot, range errors, ignored writes
    task automatic test_directed();
        quiesce();
        set_config(3, 2);
        send_item(OP_WRITE, 11'd0, 4'd0, Q_MAX, FEATURE_OOV, 1'b0);
        send_item(OP_WRITE, 11'd0, 4'd1, Q_MIN, FEATURE_EMPTY, 1'b0);
        send_item(OP_WRITE, 11'd1, 4'd0, Q_ONE, 13'sd0, 1'b0);
        send_item(OP_WRITE, 11'd1, 4'd1, -Q_ONE, 13'sd4095, 1'b0);
        send_item(OP_WRITE, 11'd3, 4'd0, Q_HALF, 13'sd0, 1'b0);
        send_item(OP_WRITE, 11'd3, 4'd1, Q_EPS_NEG, 13'sd0, 1'b0);
        // past the OOV row: dropped
        send_item(OP_WRITE, 11'h7FF, 4'hF, 32'hDEAD_BEEF, -13'sd4096, 1'b1);
        // write with bag end set must not emit
        send_item(OP_WRITE, ROW_PORT_W'(MAX_ROWS), 4'hF, 32'h1234_5678, FEATURE_OOV, 1'b1);
        send_feature(0, 1'b0);
        send_feature(0, 1'b1);
        send_feature(1, 1'b0);
        send_feature(int'(FEATURE_OOV), 1'b0);
        send_feature(int'(FEATURE_EMPTY), 1'b0);
        send_feature(3, 1'b1);
        send_feature(int'(FEATURE_EMPTY), 1'b1);
        send_feature(4095, 1'b1);
        send_feature(-4096, 1'b0);
        send_feature(-3, 1'b1);
        send_feature(2, 1'b1);
    endtask

    // out-of-range register values clamp; full-size table edges
    task automatic test_register_limits();
        quiesce();
        set_config(0, 0);
        send_feature(0, 1'b0);
        send_feature(int'(FEATURE_OOV), 1'b0);
        send_feature(1, 1'b1);
        send_feature(int'(FEATURE_EMPTY), 1'b1);
        quiesce();
        set_config(11'h7FF, 5'h1F);
        send_feature(MAX_ROWS - 1, 1'b0);
        send_feature(int'(FEATURE_OOV), 1'b1);
        quiesce();
        set_config(MAX_ROWS, MAX_DIMS);
        send_feature(0, 1'b0);
        send_feature(MAX_ROWS - 1, 1'b0);
        send_feature(MAX_ROWS, 1'b1);
    endtask

    // result side held off long enough for the input to back up
    task automatic test_backpressure();
        quiesce();
        set_config(8, MAX_DIMS);
        pop_hold_req = POP_HOLD_CYCLES;
        for (int k = 0; k < 12; k++)
        begin
            send_feature(k % 4, 1'b1);
        end
    endtask

    // random bags over a series of register settings
    task automatic test_random();
        int start;
        int phase_end;
        int n;
        int r;
        int dm;
        start = items_sent;
        phase_end = items_sent;
        while (items_sent < start + RANDOM_ITEMS)
        begin
            if (items_sent >= start + RANDOM_ITEMS - QUIET_ITEMS)
            begin
                idle_on = 1'b0;
            end
            if (items_sent >= phase_end)
            begin
                quiesce();
                case ($urandom_range(0, 9))
                    0: r = 0;
                    1: r = 11'h7FF;
                    2: r = MAX_ROWS;
                    3: r = 1;
                    default: r = $urandom_range(2, 12);
                endcase
                case ($urandom_range(0, 9))
                    0: dm = 0;
                    1: dm = 5'h1F;
                    2: dm = MAX_DIMS;
                    3: dm = 1;
                    default: dm = $urandom_range(2, 8);
                endcase
                set_config(r, dm);
                phase_end = items_sent + PHASE_ITEMS;
            end
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
            begin
                // stray table write in the middle of a bag
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(OP_WRITE, ROW_PORT_W'($urandom_range(0, 2047)),
                              COL_PORT_W'($urandom), rand_word(),
                              FEATURE_W'($urandom), 1'($urandom));
                end
                send_feature(pick_feature(), k == n - 1);
            end
        end
    endtask

    // result side: random stalls, plus long holds on request
    initial
    begin : sink
        int stall;
        stall = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pop_hold_req > 0)
            begin
                stall = pop_hold_req;
                pop_hold_req = 0;
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                stall = $urandom_range(1, 6) - 1;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // compare each popped sum with the oldest prediction
    always @(posedge clk)
    begin : check_sums
        bag_sum_t want;
        if (rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0)
        begin
            if (pending_sums.size() == 0)
            begin
                report_mismatch("unexpected sum, dimension", 32'(dimension), 32'd0);
            end
            else
            begin
                want = pending_sums.pop_front();
                if (dimension !== want.dim)
                begin
                    report_mismatch("dimension", 32'(dimension), 32'(want.dim));
                end
                if (sum_value !== want.sum)
                begin
                    report_mismatch("sum_value", sum_value, want.sum);
                end
                if (range_error !== want.err)
                begin
                    report_mismatch("range_error", 32'(range_error), 32'(want.err));
                end
                if (last_of_bag !== want.last)
                begin
                    report_mismatch("last_of_bag", 32'(last_of_bag), 32'(want.last));
                end
                sums_checked++;
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d sums still pending", cycle_count,
                 pending_sums.size());
        $display("tb_embedding_bag_sum_top: done, errors");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        opcode       = OP_WRITE;
        table_row    = '0;
        table_column = '0;
        table_value  = '0;
        feature_id   = '0;
        bag_end      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_register_limits();
        test_backpressure();
        test_random();

        quiesce();
        if (pending_sums.size() != 0)
        begin
            report_mismatch("sums never seen, count", 32'(pending_sums.size()), 32'd0);
        end
        $display("covered %0d items and %0d bags; %0d sums checked over %0d register writes",
                 items_sent, bags_closed, sums_checked, configs_written);
        $display("input held off %0d cycles; %0d mismatches", full_stall_cycles, errors);
        if (errors == 0)
        begin
            $display("tb_embedding_bag_sum_top: done, clean");
        end
        else
        begin
            $display("tb_embedding_bag_sum_top: done, errors");
        end
        $finish;
    end

endmodule
